[design/sads_pkg.sv]
package sads_pkg;

   localparam int DEF_MAX_LEN  = 1024;
   localparam int DEF_ALPHABET = 32;
   localparam int SYM_W        = 5;
   localparam int COUNT_W      = 20;

   typedef struct packed {
      logic               rejected;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

[design/sads_ram.sv]
module sads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[design/sads_core.sv]
module sads_core #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        start_restart,
   input  logic [sads_pkg::SYM_W-1:0]  start_symbol,
   output logic                        ready,
   output logic                        done_ff,
   output sads_pkg::result_type        result_ff
);
   import sads_pkg::*;

   localparam int NW     = $clog2(2 * MAX_LEN);
   localparam int LW     = $clog2(MAX_LEN + 1);
   localparam int SW     = $clog2(ALPHABET);
   localparam int AW     = NW + SW;
   localparam int NODE_W = LW + NW + ALPHABET;
   localparam int LINK_LO = ALPHABET;
   localparam int LEN_LO  = ALPHABET + NW;
   localparam logic [8:0]    ALPHA9 = 9'(ALPHABET);
   localparam logic [LW-1:0] MAXL   = LW'(MAX_LEN);
   localparam logic [SW:0]   KEND   = (SW + 1)'(ALPHABET);

   typedef enum logic [3:0] {
      IDLE, ROOT, WALK_RD, WALK_CHK, Q_RD, Q_CHK, Q_UPD, COPY, FIX_RD, FIX_CHK, FIN
   } state_type;

   state_type     state_ff;
   logic [NW-1:0] p_ff, q_ff, link_cur_ff, last_ff;
   logic [NW:0]   nc_ff;
   logic [LW-1:0] curlen_ff, slen_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [SW-1:0] sym_ff;
   logic [SW:0]   k_ff;
   logic [NODE_W-1:0] qword_ff;
   logic          need_root_ff, first_ff, cloned_ff;

   logic              node_we, trans_we;
   logic [NW-1:0]     node_wa, node_ra, trans_wd, trans_rd;
   logic [NODE_W-1:0] node_wd, node_rd;
   logic [AW-1:0]     trans_wa, trans_ra;

   logic [NW-1:0]       cur, cl, nd_link;
   logic [LW-1:0]       nd_len, p_len1;
   logic [ALPHABET-1:0] nd_mask;
   logic                nd_has;

   assign cur     = nc_ff[NW-1:0];
   assign cl      = cur + NW'(1);
   assign nd_mask = node_rd[ALPHABET-1:0];
   assign nd_link = node_rd[LINK_LO +: NW];
   assign nd_len  = node_rd[LEN_LO +: LW];
   assign nd_has  = nd_mask[sym_ff];
   assign p_len1  = qword_ff[LEN_LO +: LW];
   assign ready   = (state_ff == IDLE) && !done_ff;

   sads_ram #(.WIDTH(NODE_W), .DEPTH(2 ** NW)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data_ff(node_rd)
   );

   sads_ram #(.WIDTH(NW), .DEPTH(2 ** AW)) u_trans_ram (
      .clock(clock), .wr_en(trans_we), .wr_addr(trans_wa), .wr_data(trans_wd),
      .rd_addr(trans_ra), .rd_data_ff(trans_rd)
   );

   always_comb begin
      node_we  = 1'b0;
      node_wa  = p_ff;
      node_wd  = node_rd;
      node_ra  = p_ff;
      trans_we = 1'b0;
      trans_wa = {p_ff, sym_ff};
      trans_wd = cur;
      trans_ra = {p_ff, sym_ff};
      case (state_ff)
         ROOT: begin
            node_we = 1'b1;
            node_wa = '0;
            node_wd = '0;
         end
         WALK_CHK: begin
            if (!nd_has) begin
               node_we  = 1'b1;
               node_wd  = node_rd | NODE_W'(ALPHABET'(1) << sym_ff);
               trans_we = 1'b1;
            end
         end
         Q_RD: node_ra = q_ff;
         Q_CHK: begin
            // clone carries q's link and transition mask, len(p)+1
            if (p_len1 != nd_len) begin
               node_we = 1'b1;
               node_wa = cl;
               node_wd = {p_len1, nd_link, nd_mask};
            end
         end
         Q_UPD: begin
            node_we = 1'b1;
            node_wa = q_ff;
            node_wd = {qword_ff[LEN_LO +: LW], cl, qword_ff[ALPHABET-1:0]};
         end
         COPY: begin
            trans_ra = {q_ff, k_ff[SW-1:0]};
            if (k_ff != '0) begin
               trans_we = 1'b1;
               trans_wa = {cl, SW'(k_ff - (SW + 1)'(1))};
               trans_wd = trans_rd;
            end
         end
         FIX_CHK: begin
            if (nd_has && trans_rd == q_ff) begin
               trans_we = 1'b1;
               trans_wd = cl;
            end
         end
         FIN: begin
            node_we = 1'b1;
            node_wa = cur;
            node_wd = {curlen_ff, link_cur_ff, ALPHABET'(0)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         done_ff      <= 1'b0;
         need_root_ff <= 1'b1;
         last_ff      <= '0;
         nc_ff        <= (NW + 1)'(1);
         slen_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  sym_ff    <= SW'(start_symbol);
                  first_ff  <= 1'b1;
                  cloned_ff <= 1'b0;
                  p_ff      <= start_restart ? '0 : last_ff;
                  if (start_restart) begin
                     last_ff      <= '0;
                     nc_ff        <= (NW + 1)'(1);
                     slen_ff      <= '0;
                     cnt_ff       <= '0;
                     need_root_ff <= 1'b1;
                  end
                  if ((9'(start_symbol) >= ALPHA9) ||
                      (!start_restart && slen_ff >= MAXL)) begin
                     done_ff            <= 1'b1;
                     result_ff.rejected <= 1'b1;
                     result_ff.count    <= start_restart ? '0 : cnt_ff;
                  end else if (start_restart || need_root_ff) begin
                     state_ff <= ROOT;
                  end else begin
                     state_ff <= WALK_RD;
                  end
               end
            end
            ROOT: begin
               need_root_ff <= 1'b0;
               state_ff     <= WALK_RD;
            end
            WALK_RD: state_ff <= WALK_CHK;
            WALK_CHK: begin
               first_ff <= 1'b0;
               if (first_ff) begin
                  curlen_ff <= nd_len + LW'(1);
               end
               if (nd_has) begin
                  q_ff     <= trans_rd;
                  qword_ff <= node_rd;
                  state_ff <= Q_RD;
               end else if (p_ff == '0) begin
                  link_cur_ff <= '0;
                  cnt_ff      <= cnt_ff + COUNT_W'(first_ff ? nd_len + LW'(1) : curlen_ff);
                  state_ff    <= FIN;
               end else begin
                  p_ff     <= nd_link;
                  state_ff <= WALK_RD;
               end
            end
            Q_RD: begin
               // hold len(p)+1 in the len slot of qword while q is read
               qword_ff[LEN_LO +: LW] <= qword_ff[LEN_LO +: LW] + LW'(1);
               state_ff <= Q_CHK;
            end
            Q_CHK: begin
               if (p_len1 == nd_len) begin
                  link_cur_ff <= q_ff;
                  cnt_ff      <= cnt_ff + COUNT_W'(curlen_ff) - COUNT_W'(nd_len);
                  state_ff    <= FIN;
               end else begin
                  link_cur_ff <= cl;
                  cloned_ff   <= 1'b1;
                  cnt_ff      <= cnt_ff + COUNT_W'(curlen_ff) - COUNT_W'(p_len1);
                  qword_ff    <= node_rd;
                  k_ff        <= '0;
                  state_ff    <= Q_UPD;
               end
            end
            Q_UPD: state_ff <= COPY;
            COPY: begin
               k_ff <= k_ff + (SW + 1)'(1);
               if (k_ff == KEND) begin
                  state_ff <= FIX_RD;
               end
            end
            FIX_RD: state_ff <= FIX_CHK;
            FIX_CHK: begin
               if (nd_has && trans_rd == q_ff && p_ff != '0) begin
                  p_ff     <= nd_link;
                  state_ff <= FIX_RD;
               end else begin
                  state_ff <= FIN;
               end
            end
            FIN: begin
               last_ff            <= cur;
               nc_ff              <= nc_ff + (cloned_ff ? (NW + 1)'(2) : (NW + 1)'(1));
               slen_ff            <= slen_ff + LW'(1);
               done_ff            <= 1'b1;
               result_ff.rejected <= 1'b0;
               result_ff.count    <= cnt_ff;
               state_ff           <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

[design/suffix_automaton_distinct_substrings_top.sv]
// Online suffix automaton: appends one symbol per request beat and returns
// the number of distinct nonempty substrings of the string built so far.
//
// Request channel (req_): tdata carries the symbol, tuser the restart flag.
// A restart beat empties the automaton before its symbol is appended.
// Response channel (rsp_): one beat per request, tdata the running count,
// tuser the rejected flag (symbol out of range or string at capacity).
//
// Timing: one request at a time. An append walks the suffix links from the
// last node; a found transition adds a length check of its target, a clone
// adds a copy of the transition row and a pass that redirects transitions
// along the links; the first append after reset or restart adds a root write.
// The node and transition memories each have one write port and one
// registered read port. A rejected beat is answered from idle without a walk.
// A new request can be taken in the same cycle the response shows, if the receiver takes the response then.
// A transition counts as present only when the node's mask bit is set, so
// neither reset nor restart needs a clearing pass; the root entry is
// rewritten at the first append after either.
// Reset clears the FSM, counters and response valid. On a receiver stall
// the response holds in its output register and no new request is taken.
module suffix_automaton_distinct_substrings_top #(
   parameter int MAX_LEN  = sads_pkg::DEF_MAX_LEN,
   parameter int ALPHABET = sads_pkg::DEF_ALPHABET
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] symbol, [7:5] zero
   input  logic [0:0]  req_tuser,   // [0] req_type (restart)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] distinct_count, [23:20] zero
   output logic [0:0]  rsp_tuser    // [0] rejected
);
   import sads_pkg::*;

   logic       core_ready, core_done, start;
   result_type core_result;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   // take a beat only when the output slot is free or drains this cycle
   assign req_tready = core_ready && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;

   sads_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_core (
      .clock(clock), .reset(reset), .start(start),
      .start_restart(req_tuser[0]), .start_symbol(req_tdata[SYM_W-1:0]),
      .ready(core_ready), .done_ff(core_done), .result_ff(core_result)
   );

   // output register: load on done, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= core_result;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {4'b0, rsp_ff.count};
   assign rsp_tuser[0] = rsp_ff.rejected;

endmodule

[design/sads_checker.sv]
module sads_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !(req_tvalid && req_tready))
      else $error("two request beats in a row");

   a_accept_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken while response slot is blocked");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind suffix_automaton_distinct_substrings_top sads_props u_sads_props (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

[tb/sads_checker.sv]
`timescale 1ns / 1ps

module sads_checker #(
   parameter int MAX_LEN  = sads_pkg::DEF_MAX_LEN,
   parameter int ALPHABET = sads_pkg::DEF_ALPHABET
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen,
   output int          rej_seen
);
   import sads_pkg::*;

   localparam int NODES = 2 * MAX_LEN;

   // predictor copy of the automaton
   int unsigned node_len  [NODES];
   int unsigned node_link [NODES];
   int unsigned node_next [NODES][ALPHABET];
   int unsigned tail_node, n_nodes, str_len;
   int unsigned sub_count;

   result_type count_q[$];

   task automatic empty_automaton();
      foreach (node_next[i, j]) node_next[i][j] = 0;
      node_len[0] = 0;
      node_link[0] = 0;
      tail_node = 0;
      n_nodes = 1;
      str_len = 0;
      sub_count = 0;
   endtask

   task automatic append_symbol(input int unsigned c);
      int unsigned cur, p, q, cl;
      bit hit;
      cur = n_nodes++;
      p = tail_node;
      hit = 0;
      node_len[cur] = node_len[p] + 1;
      forever begin
         if (node_next[p][c] != 0) begin
            hit = 1;
            break;
         end
         node_next[p][c] = cur;
         if (p == 0) break;
         p = node_link[p];
      end
      if (!hit) begin
         node_link[cur] = 0;
         sub_count += node_len[cur];
      end else begin
         q = node_next[p][c];
         if (node_len[p] + 1 == node_len[q]) begin
            node_link[cur] = q;
            sub_count += node_len[cur] - node_len[q];
         end else begin
            cl = n_nodes++;
            node_len[cl] = node_len[p] + 1;
            node_link[cl] = node_link[q];
            for (int k = 0; k < ALPHABET; k++) node_next[cl][k] = node_next[q][k];
            node_link[q] = cl;
            node_link[cur] = cl;
            sub_count += node_len[cur] - node_len[cl];
            forever begin
               if (node_next[p][c] != q) break;
               node_next[p][c] = cl;
               if (p == 0) break;
               p = node_link[p];
            end
         end
      end
      tail_node = cur;
      str_len++;
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("checker: mismatch %s got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      rsp_seen = 0;
      rej_seen = 0;
      empty_automaton();
   end

   always @(posedge clock) begin
      result_type want, got;
      int unsigned sym;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sym = {27'b0, req_tdata[SYM_W-1:0]};
            if (req_tuser[0]) empty_automaton();
            want.rejected = (sym >= ALPHABET || str_len >= MAX_LEN);
            if (!want.rejected) append_symbol(sym);
            want.count = COUNT_W'(sub_count);
            count_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.count = rsp_tdata[COUNT_W-1:0];
            got.rejected = rsp_tuser[0];
            rsp_seen++;
            if (got.rejected) rej_seen++;
            if (count_q.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               want = count_q.pop_front();
               if (got.count !== want.count)
                  report("distinct_count", int'(got.count), int'(want.count));
               if (got.rejected !== want.rejected)
                  report("rejected", int'(got.rejected), int'(want.rejected));
               if (rsp_tdata[23:COUNT_W] !== '0)
                  report("tdata pad", int'(rsp_tdata[23:COUNT_W]), 0);
            end
         end
         pending = count_q.size();
      end
   end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import sads_pkg::*;

   localparam int MAX_LEN    = DEF_MAX_LEN;
   localparam int CYCLE_CAP  = 2_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   int fail_count, pending, rsp_seen, rej_seen;
   int send_idle_pct = 0;    // percent of cycles the sender holds off
   int recv_idle_pct = 0;    // percent of cycles the receiver stalls
   int hold_off_left = 0;    // long receiver stall, counted down per cycle
   int hold_req = 0;         // bumped by the stimulus to ask for a long stall
   int hold_ack = 0;
   int cycles = 0;
   int sent = 0;

   always #6 clock = ~clock;

   suffix_automaton_distinct_substrings_top uut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   sads_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending, .rsp_seen, .rej_seen
   );

   // receiver: random stalls, or a long hold-off while it counts down
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack      <= hold_req;
         hold_off_left <= 300;
         rsp_tready    <= 0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // offer one beat, idling at random first; hold until accepted and keep
   // valid up so the next beat can follow without a gap
   task automatic send_beat(input bit restart, input logic [4:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {3'b000, sym};
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random body: mostly short strings over small alphabets so that links
   // and clones get exercised; now and then the full alphabet or a longer run
   task automatic random_phase(input int n_items);
      int alpha, run_len;
      int done;
      done = 0;
      while (done < n_items) begin
         alpha = ($urandom_range(9) == 0) ? 32 : $urandom_range(4, 1);
         run_len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(30, 1);
         send_beat(1'b1, 5'($urandom_range(alpha - 1)));
         done++;
         for (int i = 1; i < run_len && done < n_items; i++) begin
            send_beat($urandom_range(49) == 0, 5'($urandom_range(alpha - 1)));
            done++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: both symbol extremes, repeats, a clone-forcing pattern
      send_beat(1'b0, 5'd0);
      send_beat(1'b0, 5'd31);
      send_beat(1'b0, 5'd0);
      send_beat(1'b0, 5'd0);
      send_beat(1'b0, 5'd31);
      send_beat(1'b1, 5'd1);   // restart then append
      send_beat(1'b0, 5'd2);
      send_beat(1'b0, 5'd1);
      send_beat(1'b0, 5'd1);
      send_beat(1'b0, 5'd2);
      send_beat(1'b0, 5'd1);
      send_beat(1'b1, 5'd21);
      send_beat(1'b0, 5'd10);
      wait_drained();   // sender pauses until all results are back

      // fill to capacity, then check rejection and restart out of a full string
      send_idle_pct = 0;
      send_beat(1'b1, 5'd0);
      for (int i = 1; i < MAX_LEN; i++) send_beat(1'b0, 5'($urandom_range(3)));
      send_beat(1'b0, 5'd1);   // rejected, string full
      send_beat(1'b0, 5'd31);  // rejected again
      send_beat(1'b1, 5'd3);   // restart still works
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      hold_req = hold_req + 1;
      for (int i = 0; i < 8; i++) send_beat(1'b0, 5'($urandom_range(31)));
      wait_drained();

      send_idle_pct = 13; recv_idle_pct = 69;
      random_phase(120);
      send_idle_pct = 69; recv_idle_pct = 13;
      random_phase(120);
      send_idle_pct = 0;  recv_idle_pct = 0;
      random_phase(120);

      wait_drained();
      repeat (200) @(posedge clock);
      $display("tb: %0d request beats, %0d responses, %0d rejected", sent, rsp_seen,
               rej_seen);
      $display("tb: covered restarts, capacity fill, clones and stalls on both sides");
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
